// ===== rtl/core/cqr_pkg.sv =====
// Shared types and fixed constants for the circular queue with in-place reverse.
// No dependencies; used by circular_queue_with_reverse_top and the testbench.
package cqr_pkg;

   localparam int unsigned LEN_BITS  = 4;
   localparam int unsigned DATA_BITS = 32;

   typedef enum logic [1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_CLR = 2'd2,
      OP_REV = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DEQ,
      S_SWAP_A,
      S_SWAP_B,
      S_SWAP_C,
      S_SWAP_D
   } state_type;

endpackage

// ===== rtl/core/circular_queue_with_reverse_top.sv =====
// Circular queue with in-place reverse. Enqueue, clear and refused operations finish
// in S_EXEC, a dequeue finishes in S_DEQ after its slot read, and a reverse of n stored
// words first runs floor(n/2) swaps; busy stays high until the result strobe.
// Each swap passes S_SWAP_A to S_SWAP_D, using one memory read port and one write port.
// Synchronous active-high reset empties the queue; slot contents are not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
module circular_queue_with_reverse_top #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_data_in,
   output logic               rsp_valid,
   output logic               rsp_status,
   output logic signed [31:0] rsp_data_out,
   output logic [3:0]         rsp_length,
   output logic               rsp_is_empty,
   output logic               rsp_is_full
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = (IDX_W > cqr_pkg::LEN_BITS) ? IDX_W : cqr_pkg::LEN_BITS;
   localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
   localparam logic [IDX_W-1:0] FULL_N  = IDX_W'(DEPTH - 1);

   // Ring occupancy: (tail - head) mod DEPTH.
   function automatic logic [IDX_W-1:0] ring_count(input logic [IDX_W-1:0] hd,
                                                   input logic [IDX_W-1:0] tl);
      logic [IDX_W:0] diff;
      begin
         if (tl >= hd) begin
            diff = {1'b0, tl} - {1'b0, hd};
         end else begin
            diff = {1'b0, tl} + DEPTH_X - {1'b0, hd};
         end
         ring_count = diff[IDX_W-1:0];
      end
   endfunction

   cqr_pkg::state_type state_ff, state_in;
   cqr_pkg::op_type    op_ff, op_in;
   logic [31:0]        data_ff, data_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [IDX_W-1:0]   swaps_ff, swaps_in;
   logic [WORD_BITS-1:0] hold_ff, hold_in;
   logic [WORD_BITS-1:0] rd_data_ff;

   logic [WORD_BITS-1:0] slot_mem [DEPTH];

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [IDX_W-1:0]     rd_addr;

   logic [IDX_W-1:0]     step_idx;
   logic                 step_dec;
   logic [IDX_W-1:0]     step_out;

   logic                 finish;
   logic                 status_in;
   logic [31:0]          dout_in;
   logic [IDX_W-1:0]     count_cur;
   logic [IDX_W-1:0]     count_nxt;
   logic [CNT_W-1:0]     len_wide;

   logic [WORD_BITS-1:0] enq_word;
   logic [31:0]          deq_word;

   logic                 rsp_valid_ff;
   logic                 rsp_status_ff;
   logic [31:0]          rsp_data_ff;
   logic [3:0]           rsp_length_ff;
   logic                 rsp_is_empty_ff;
   logic                 rsp_is_full_ff;

   cqr_ring_step #(
      .DEPTH (DEPTH)
   ) u_step (
      .idx     (step_idx),
      .dec     (step_dec),
      .idx_out (step_out)
   );

   // Fit the 32-bit beat to the stored word and sign-extend on the way out.
   generate
      if (WORD_BITS > 32) begin : g_wide
         assign enq_word = {{(WORD_BITS - 32){1'b0}}, data_ff};
         assign deq_word = rd_data_ff[31:0];
      end else if (WORD_BITS == 32) begin : g_exact
         assign enq_word = data_ff;
         assign deq_word = rd_data_ff;
      end else begin : g_narrow
         assign enq_word = data_ff[WORD_BITS-1:0];
         assign deq_word = {{(32 - WORD_BITS){rd_data_ff[WORD_BITS-1]}}, rd_data_ff};
      end
   endgenerate

   assign count_cur = ring_count(head_ff, tail_ff);
   assign count_nxt = ring_count(head_in, tail_in);
   assign len_wide  = CNT_W'(count_nxt);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      data_in   = data_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      swaps_in  = swaps_ff;
      hold_in   = hold_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      wr_data   = enq_word;
      rd_addr   = head_ff;
      step_idx  = tail_ff;
      step_dec  = 1'b0;
      finish    = 1'b0;
      status_in = 1'b0;
      dout_in   = '0;

      case (state_ff)
         cqr_pkg::S_IDLE: begin
            if (start) begin
               op_in    = cqr_pkg::op_type'(req_op);
               data_in  = req_data_in;
               state_in = cqr_pkg::S_EXEC;
            end
         end
         cqr_pkg::S_EXEC: begin
            case (op_ff)
               cqr_pkg::OP_ENQ: begin
                  step_idx = tail_ff;
                  finish   = 1'b1;
                  state_in = cqr_pkg::S_IDLE;
                  if (step_out == head_ff) begin
                     status_in = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     tail_in = step_out;
                  end
               end
               cqr_pkg::OP_DEQ: begin
                  if (head_ff == tail_ff) begin
                     status_in = 1'b1;
                     finish    = 1'b1;
                     state_in  = cqr_pkg::S_IDLE;
                  end else begin
                     rd_addr  = head_ff;
                     state_in = cqr_pkg::S_DEQ;
                  end
               end
               cqr_pkg::OP_CLR: begin
                  head_in  = '0;
                  tail_in  = '0;
                  finish   = 1'b1;
                  state_in = cqr_pkg::S_IDLE;
               end
               cqr_pkg::OP_REV: begin
                  // Reverse in place between head and tail - 1; pointers stay.
                  step_idx = tail_ff;
                  step_dec = 1'b1;
                  lo_in    = head_ff;
                  hi_in    = step_out;
                  swaps_in = count_cur >> 1;
                  if (count_cur < IDX_W'(2)) begin
                     finish   = 1'b1;
                     state_in = cqr_pkg::S_IDLE;
                  end else begin
                     state_in = cqr_pkg::S_SWAP_A;
                  end
               end
               default: begin
                  finish   = 1'b1;
                  state_in = cqr_pkg::S_IDLE;
               end
            endcase
         end
         cqr_pkg::S_DEQ: begin
            dout_in  = deq_word;
            step_idx = head_ff;
            head_in  = step_out;
            finish   = 1'b1;
            state_in = cqr_pkg::S_IDLE;
         end
         cqr_pkg::S_SWAP_A: begin
            rd_addr  = lo_ff;
            state_in = cqr_pkg::S_SWAP_B;
         end
         cqr_pkg::S_SWAP_B: begin
            // Low word has landed; hold it and fetch the high word.
            hold_in  = rd_data_ff;
            rd_addr  = hi_ff;
            state_in = cqr_pkg::S_SWAP_C;
         end
         cqr_pkg::S_SWAP_C: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = rd_data_ff;
            step_idx = lo_ff;
            lo_in    = step_out;
            state_in = cqr_pkg::S_SWAP_D;
         end
         cqr_pkg::S_SWAP_D: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = hold_ff;
            step_idx = hi_ff;
            step_dec = 1'b1;
            hi_in    = step_out;
            swaps_in = swaps_ff - IDX_W'(1);
            if (swaps_ff == IDX_W'(1)) begin
               finish   = 1'b1;
               state_in = cqr_pkg::S_IDLE;
            end else begin
               state_in = cqr_pkg::S_SWAP_A;
            end
         end
         default: begin
            state_in = cqr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cqr_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      data_ff  <= data_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      swaps_ff <= swaps_in;
      hold_ff  <= hold_in;
      if (finish) begin
         rsp_status_ff   <= status_in;
         rsp_data_ff     <= dout_in;
         rsp_length_ff   <= len_wide[3:0];
         rsp_is_empty_ff <= (head_in == tail_in);
         rsp_is_full_ff  <= (count_nxt == FULL_N);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign busy         = (state_ff != cqr_pkg::S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full  = rsp_is_full_ff;

endmodule

// ===== rtl/core/cqr_ring_step.sv =====
// Shared ring-index stepper: one wrapping increment or decrement modulo DEPTH.
// Depends on nothing; instantiated once by circular_queue_with_reverse_top.
module cqr_ring_step #(
   parameter int DEPTH = 16
) (
   input  logic [$clog2(DEPTH)-1:0] idx,
   input  logic                     dec,
   output logic [$clog2(DEPTH)-1:0] idx_out
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

   always_comb begin
      if (dec) begin
         idx_out = (idx == '0) ? LAST : idx - IDX_W'(1);
      end else begin
         idx_out = (idx == LAST) ? '0 : idx + IDX_W'(1);
      end
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for circular_queue_with_reverse_top: a directed table, then biased random beats.
// Each result is checked against a typed table value or an in-bench ring model. Needs cqr_pkg and the top-level RTL.
module tb;

   localparam int RING_DEPTH   = 16;
   localparam int ITEM_BITS    = 32;
   localparam int RANDOM_BEATS = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic        status;
      logic [31:0] dout;
      logic [3:0]  len;
      logic        empty;
      logic        full;
   } queue_result_type;

   typedef struct packed {
      cqr_pkg::op_type  op;
      logic [31:0]      word;
      logic             typed;
      queue_result_type res;
   } plan_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_op = cqr_pkg::OP_ENQ;
   logic signed [31:0] req_data_in = '0;
   logic               busy;
   logic               rsp_valid;
   logic               rsp_status;
   logic signed [31:0] rsp_data_out;
   logic [3:0]         rsp_length;
   logic               rsp_is_empty;
   logic               rsp_is_full;

   circular_queue_with_reverse_top #(
      .DEPTH     (RING_DEPTH),
      .WORD_BITS (ITEM_BITS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_length   (rsp_length),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full)
   );

   // Ring model: 4-bit indexes wrap at RING_DEPTH by themselves.
   logic [31:0]   ring [RING_DEPTH];
   logic [3:0]    head_ix = '0;
   logic [3:0]    tail_ix = '0;

   queue_result_type pending_results [$];
   int            mismatch_count = 0;
   int            checked_count  = 0;
   int            refused_count  = 0;
   int            full_seen      = 0;
   int            beat_count [4] = '{default: 0};
   int            idle_pct       = 0;
   int            quiet_cycles   = 0;

   plan_row_type plan [25] = '{
      '{cqr_pkg::OP_DEQ, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 4'd0, 1'b1, 1'b0}},
      '{cqr_pkg::OP_REV, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 4'd0, 1'b1, 1'b0}},
      '{cqr_pkg::OP_ENQ, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, 4'd1, 1'b0, 1'b0}},
      '{cqr_pkg::OP_ENQ, 32'h8000_0000, 1'b1, '{1'b0, 32'h0, 4'd2, 1'b0, 1'b0}},
      '{cqr_pkg::OP_ENQ, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 4'd3, 1'b0, 1'b0}},
      '{cqr_pkg::OP_ENQ, 32'hFFFF_FFFF, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'h5555_5555, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'hAAAA_AAAA, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'h0000_0001, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'h1234_5678, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'h89AB_CDEF, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'h0F0F_0F0F, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'hF0F0_F0F0, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'h7FFF_8000, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'h8000_7FFF, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'h0001_0000, 1'b0, '0},
      '{cqr_pkg::OP_ENQ, 32'hFFFE_FFFF, 1'b1, '{1'b0, 32'h0, 4'd15, 1'b0, 1'b1}},
      '{cqr_pkg::OP_ENQ, 32'hDEAD_BEEF, 1'b1, '{1'b1, 32'h0, 4'd15, 1'b0, 1'b1}},
      '{cqr_pkg::OP_REV, 32'h0000_0000, 1'b0, '0},
      '{cqr_pkg::OP_DEQ, 32'h0000_0000, 1'b0, '0},
      '{cqr_pkg::OP_DEQ, 32'h0000_0000, 1'b0, '0},
      '{cqr_pkg::OP_CLR, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 4'd0, 1'b1, 1'b0}},
      '{cqr_pkg::OP_DEQ, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 4'd0, 1'b1, 1'b0}},
      '{cqr_pkg::OP_ENQ, 32'h00C0_FFEE, 1'b0, '0},
      '{cqr_pkg::OP_REV, 32'h0000_0000, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic queue_result_type apply_queue_op(cqr_pkg::op_type op,
                                                       logic [31:0] word);
      queue_result_type r;
      logic [31:0]   snap [RING_DEPTH];
      logic [3:0]    n;
      r = '0;
      case (op)
         cqr_pkg::OP_ENQ: begin
            if (4'(tail_ix + 4'd1) == head_ix) begin
               r.status = 1'b1;
            end else begin
               ring[tail_ix] = word;
               tail_ix = tail_ix + 4'd1;
            end
         end
         cqr_pkg::OP_DEQ: begin
            if (head_ix == tail_ix) begin
               r.status = 1'b1;
            end else begin
               r.dout = ring[head_ix];
               head_ix = head_ix + 4'd1;
            end
         end
         cqr_pkg::OP_CLR: begin
            head_ix = '0;
            tail_ix = '0;
         end
         default: begin
            // new front is the old tail slot; words laid down from there newest first
            snap = ring;
            n = tail_ix - head_ix;
            for (int i = 0; i < n; i++)
               ring[4'(tail_ix + 4'(i))] = snap[4'(head_ix + n - 4'd1 - 4'(i))];
            head_ix = tail_ix;
            tail_ix = tail_ix + n;
         end
      endcase
      r.len   = tail_ix - head_ix;
      r.empty = (head_ix == tail_ix);
      r.full  = (4'(tail_ix + 4'd1) == head_ix);
      return r;
   endfunction

   task automatic send_beat(cqr_pkg::op_type op, logic [31:0] word, logic typed,
                            queue_result_type typed_res);
      queue_result_type predicted;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_op      <= op;
      req_data_in <= word;
      do @(posedge clock); while (busy);
      predicted = apply_queue_op(op, word);
      pending_results.push_back(typed ? typed_res : predicted);
      beat_count[op]++;
      if (predicted.status) refused_count++;
      if (predicted.full) full_seen++;
   endtask

   always @(posedge clock) begin : result_check
      queue_result_type got;
      queue_result_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_status, rsp_data_out, rsp_length, rsp_is_empty, rsp_is_full};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: status %0b data %h len %0d empty %0b full %0b",
                        got.status, got.dout, got.len, got.empty, got.full);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"result %0d mismatch: expected status %0b data %h len %0d ",
                            "empty %0b full %0b, got status %0b data %h len %0d ",
                            "empty %0b full %0b"},
                           checked_count, want.status, want.dout, want.len, want.empty,
                           want.full, got.status, got.dout, got.len, got.empty, got.full);
            end
         end
      end
   end

   // Count cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, pending_results.size());
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cqr_pkg::op_type op;
      logic [31:0]     word;
      int              roll;
      logic            filling;
      filling = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 24;
      foreach (plan[k])
         send_beat(plan[k].op, plan[k].word, plan[k].typed, plan[k].res);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 24 : (phase == 1) ? 62 : 0;
         for (int k = 0; k < RANDOM_BEATS / 3 + 1; k++) begin
            // swing between filling and draining so both full and empty get hit often
            if (4'(tail_ix + 4'd1) == head_ix) filling = 1'b0;
            else if (head_ix == tail_ix) filling = 1'b1;
            roll = $urandom_range(99);
            if (filling) begin
               if (roll < 68)      op = cqr_pkg::OP_ENQ;
               else if (roll < 83) op = cqr_pkg::OP_DEQ;
               else if (roll < 97) op = cqr_pkg::OP_REV;
               else                op = cqr_pkg::OP_CLR;
            end else begin
               if (roll < 15)      op = cqr_pkg::OP_ENQ;
               else if (roll < 80) op = cqr_pkg::OP_DEQ;
               else if (roll < 97) op = cqr_pkg::OP_REV;
               else                op = cqr_pkg::OP_CLR;
            end
            if ($urandom_range(7) == 0) begin
               case ($urandom_range(3))
                  0:       word = 32'h0000_0000;
                  1:       word = 32'hFFFF_FFFF;
                  2:       word = 32'h7FFF_FFFF;
                  default: word = 32'h8000_0000;
               endcase
            end else begin
               word = $urandom;
            end
            send_beat(op, word, 1'b0, '0);
         end
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display({"covered %0d beats (enqueue %0d, dequeue %0d, clear %0d, reverse %0d) ",
                "at three idle rates"},
               beat_count[0] + beat_count[1] + beat_count[2] + beat_count[3],
               beat_count[cqr_pkg::OP_ENQ], beat_count[cqr_pkg::OP_DEQ],
               beat_count[cqr_pkg::OP_CLR], beat_count[cqr_pkg::OP_REV]);
      $display("%0d refused, %0d full states, %0d results checked, %0d mismatches",
               refused_count, full_seen, checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
